[rtl/core/impq_pkg.sv]
// ----------------------------------------------------------------------------
// impq_pkg
// Types and codes shared by the indexed min-heap priority queue.
// ----------------------------------------------------------------------------
package impq_pkg;

   localparam int DEF_VERTICES = 1024;
   localparam int DEF_KEY_BITS = 31;

   localparam logic [1:0] FUNC_INSERT   = 2'd0;
   localparam logic [1:0] FUNC_DELETE   = 2'd1;
   localparam logic [1:0] FUNC_DECREASE = 2'd2;

   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_ALREADY     = 3'd1;
   localparam logic [2:0] STATUS_NOT_QUEUED  = 3'd2;
   localparam logic [2:0] STATUS_EMPTY       = 3'd3;
   localparam logic [2:0] STATUS_NOT_SMALLER = 3'd4;

   typedef struct packed {
      logic [1:0]  func;
      logic [9:0]  vertex;
      logic [30:0] key;
   } impq_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  out_vertex;
      logic [30:0] out_key;
      logic [10:0] queue_count;
      logic        queue_empty;
   } impq_rsp_type;

endpackage

[rtl/core/indexed_min_heap_priority_queue.sv]
// ----------------------------------------------------------------------------
// indexed_min_heap_priority_queue
// Indexed binary min-heap of vertex numbers ordered by per-vertex keys.
// ----------------------------------------------------------------------------
// A transaction is taken at a clock edge where start is high and busy is low;
// req_data carries the operation (insert, delete minimum, decrease key), the
// vertex and the key. Exactly one result follows per transaction: rsp_data is
// valid for the single cycle in which rsp_strobe is high. The receiver cannot
// stall, so a result is never held.
// Order of work from the accepting edge to the strobe: delete on an empty
// queue, the unused code and an out-of-range vertex answer from idle; insert
// and decrease key first read the slot map, where a vertex found already
// queued or absent answers, and decrease key then reads the old key, where a
// key that is not smaller answers. Insert and decrease key then climb the
// heap from the new slot; delete minimum reads the root and the last entry and
// descends. Each level costs one heap memory read and one compare/write step;
// the moving entry is held in a register and written once when it settles.
// One transaction at a time: busy drops in the strobe cycle, so the next one
// can be taken at the edge that ends it.
// Heap slots and keys share one memory (two read ports, one write port);
// the vertex-to-slot map is a second memory. After reset the block clears
// the slot map, one entry per cycle, with busy high.
// ----------------------------------------------------------------------------
module indexed_min_heap_priority_queue #(
   parameter int VERTICES = impq_pkg::DEF_VERTICES,
   parameter int KEY_BITS = impq_pkg::DEF_KEY_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  impq_pkg::impq_req_type req_data,
   output logic                   rsp_strobe,
   output impq_pkg::impq_rsp_type rsp_data
);
   import impq_pkg::*;

   localparam int VIW = $clog2(VERTICES);
   localparam int SW  = $clog2(VERTICES + 1);
   localparam int KW  = KEY_BITS;
   localparam int EW  = VIW + KW;

   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_LOOK    = 4'd2;
   localparam logic [3:0] ST_DEC     = 4'd3;
   localparam logic [3:0] ST_UP      = 4'd4;
   localparam logic [3:0] ST_UP_CMP  = 4'd5;
   localparam logic [3:0] ST_DEL     = 4'd6;
   localparam logic [3:0] ST_DN      = 4'd7;
   localparam logic [3:0] ST_DN_CMP  = 4'd8;
   localparam logic [3:0] ST_DEL_CLR = 4'd9;

   // memories
   logic [EW-1:0] heap_mem [0:VERTICES];
   logic [SW-1:0] pos_mem  [0:VERTICES-1];

   logic [SW-1:0]  ha_addr, hb_addr, hw_addr;
   logic [EW-1:0]  ha_q, hb_q, hw_data;
   logic           hw_en;
   logic [VIW-1:0] pr_addr, pw_addr;
   logic [SW-1:0]  pr_q, pw_data;
   logic           pw_en;

   // control and payload registers
   logic [3:0]     state_ff, state_in;
   logic [SW-1:0]  count_ff, count_in;
   logic [VIW-1:0] clr_ff, clr_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   impq_rsp_type   rsp_ff, rsp_in;
   logic [1:0]     func_ff, func_in;
   logic [VIW-1:0] v_ff, v_in;
   logic [KW-1:0]  k_ff, k_in;
   logic [SW-1:0]  s_ff, s_in;
   logic [EW-1:0]  x_ff, x_in;
   logic [EW-1:0]  m_ff, m_in;
   logic           right_ok_ff, right_ok_in;

   // response assembly
   logic           resp_go;
   logic [2:0]     resp_status;
   logic [VIW-1:0] resp_vertex;
   logic [KW-1:0]  resp_key;

   // sift-down helpers
   logic [SW:0]    dbl, c_ext;
   logic           down_leaf, right_ok_c, take_right;
   logic [EW-1:0]  child;
   logic [SW-1:0]  child_slot;
   logic           req_oob;

   assign dbl        = {s_ff, 1'b0};
   assign c_ext      = {1'b0, count_ff};
   assign down_leaf  = dbl > c_ext;
   assign right_ok_c = dbl < c_ext;
   assign take_right = right_ok_ff && (hb_q[KW-1:0] < ha_q[KW-1:0]);
   assign child      = take_right ? hb_q : ha_q;
   assign child_slot = take_right ? {s_ff[SW-2:0], 1'b1} : {s_ff[SW-2:0], 1'b0};
   assign req_oob    = 32'(req_data.vertex) >= 32'(VERTICES);

   always_ff @(posedge clock) begin
      ha_q <= heap_mem[ha_addr];
      hb_q <= heap_mem[hb_addr];
      if (hw_en) begin
         heap_mem[hw_addr] <= hw_data;
      end
   end

   always_ff @(posedge clock) begin
      pr_q <= pos_mem[pr_addr];
      if (pw_en) begin
         pos_mem[pw_addr] <= pw_data;
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      clr_in      = clr_ff;
      func_in     = func_ff;
      v_in        = v_ff;
      k_in        = k_ff;
      s_in        = s_ff;
      x_in        = x_ff;
      m_in        = m_ff;
      right_ok_in = right_ok_ff;
      ha_addr     = s_ff;
      hb_addr     = s_ff;
      hw_en       = 1'b0;
      hw_addr     = s_ff;
      hw_data     = x_ff;
      pr_addr     = v_ff;
      pw_en       = 1'b0;
      pw_addr     = x_ff[EW-1:KW];
      pw_data     = s_ff;
      resp_go     = 1'b0;
      resp_status = STATUS_OK;
      resp_vertex = '0;
      resp_key    = '0;

      case (state_ff)
         ST_CLEAR: begin
            pw_en   = 1'b1;
            pw_addr = clr_ff;
            pw_data = '0;
            clr_in  = clr_ff + VIW'(1);
            if (clr_ff == VIW'(VERTICES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               func_in = req_data.func;
               v_in    = VIW'(req_data.vertex);
               k_in    = KW'(req_data.key);
               case (req_data.func)
                  FUNC_INSERT, FUNC_DECREASE: begin
                     if (req_oob) begin
                        resp_go     = 1'b1;
                        resp_status = STATUS_NOT_QUEUED;
                     end else begin
                        pr_addr  = VIW'(req_data.vertex);
                        state_in = ST_LOOK;
                     end
                  end
                  FUNC_DELETE: begin
                     if (count_ff == '0) begin
                        resp_go     = 1'b1;
                        resp_status = STATUS_EMPTY;
                     end else begin
                        ha_addr  = SW'(1);
                        hb_addr  = count_ff;
                        state_in = ST_DEL;
                     end
                  end
                  default: begin
                     resp_go = 1'b1;
                  end
               endcase
            end
         end
         ST_LOOK: begin
            if (func_ff == FUNC_INSERT) begin
               if (pr_q != '0) begin
                  resp_go     = 1'b1;
                  resp_status = STATUS_ALREADY;
                  state_in    = ST_IDLE;
               end else begin
                  count_in = count_ff + SW'(1);
                  s_in     = count_ff + SW'(1);
                  x_in     = {v_ff, k_ff};
                  state_in = ST_UP;
               end
            end else begin
               if (pr_q == '0) begin
                  resp_go     = 1'b1;
                  resp_status = STATUS_NOT_QUEUED;
                  state_in    = ST_IDLE;
               end else begin
                  ha_addr  = pr_q;
                  s_in     = pr_q;
                  state_in = ST_DEC;
               end
            end
         end
         ST_DEC: begin
            if (k_ff >= ha_q[KW-1:0]) begin
               resp_go     = 1'b1;
               resp_status = STATUS_NOT_SMALLER;
               state_in    = ST_IDLE;
            end else begin
               x_in     = {v_ff, k_ff};
               state_in = ST_UP;
            end
         end
         ST_UP: begin
            if (s_ff == SW'(1)) begin
               // settle at the root
               hw_en    = 1'b1;
               pw_en    = 1'b1;
               resp_go  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               ha_addr  = s_ff >> 1;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (x_ff[KW-1:0] < ha_q[KW-1:0]) begin
               // pull the parent down into the hole
               hw_en    = 1'b1;
               hw_data  = ha_q;
               pw_en    = 1'b1;
               pw_addr  = ha_q[EW-1:KW];
               s_in     = s_ff >> 1;
               state_in = ST_UP;
            end else begin
               hw_en    = 1'b1;
               pw_en    = 1'b1;
               resp_go  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DEL: begin
            m_in     = ha_q;
            x_in     = hb_q;
            count_in = count_ff - SW'(1);
            s_in     = SW'(1);
            state_in = ST_DN;
         end
         ST_DN: begin
            if (down_leaf) begin
               hw_en    = 1'b1;
               pw_en    = 1'b1;
               state_in = ST_DEL_CLR;
            end else begin
               ha_addr     = dbl[SW-1:0];
               hb_addr     = right_ok_c ? {s_ff[SW-2:0], 1'b1} : dbl[SW-1:0];
               right_ok_in = right_ok_c;
               state_in    = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            if (child[KW-1:0] < x_ff[KW-1:0]) begin
               // lift the smaller child into the hole
               hw_en    = 1'b1;
               hw_data  = child;
               pw_en    = 1'b1;
               pw_addr  = child[EW-1:KW];
               s_in     = child_slot;
               state_in = ST_DN;
            end else begin
               hw_en    = 1'b1;
               pw_en    = 1'b1;
               state_in = ST_DEL_CLR;
            end
         end
         ST_DEL_CLR: begin
            // drop the removed vertex last, so it wins over a root rewrite
            pw_en       = 1'b1;
            pw_addr     = m_ff[EW-1:KW];
            pw_data     = '0;
            resp_go     = 1'b1;
            resp_vertex = m_ff[EW-1:KW];
            resp_key    = m_ff[KW-1:0];
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_strobe_in = resp_go;
      rsp_in        = rsp_ff;
      if (resp_go) begin
         rsp_in.status      = resp_status;
         rsp_in.out_vertex  = 10'(resp_vertex);
         rsp_in.out_key     = 31'(resp_key);
         rsp_in.queue_count = 11'(count_in);
         rsp_in.queue_empty = (count_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         count_ff      <= '0;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      func_ff     <= func_in;
      v_ff        <= v_in;
      k_ff        <= k_in;
      s_ff        <= s_in;
      x_ff        <= x_in;
      m_ff        <= m_in;
      right_ok_ff <= right_ok_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
